### design/ufbd_pkg.sv
// ----------------------------------------------------------------------------
// ufbd_pkg: shared types and constants for the fractional baud divisor
// Field widths, datapath widths, status codes and sequencer states.
// ----------------------------------------------------------------------------
package ufbd_pkg;

  // Item field widths
  localparam int CLK_W  = 26;
  localparam int BAUD_W = 24;
  localparam int DIVL_W = 16;
  localparam int MUL_W  = 4;
  localparam int ADD_W  = 4;
  localparam int STAT_W = 2;

  // Datapath widths
  localparam int D_W     = BAUD_W + 4;       // 16 * baud
  localparam int T_W     = 5;                // trial factor in tenths
  localparam int Q_W     = D_W + T_W;        // d * t
  localparam int L_W     = 22;               // trial divisor latch value
  localparam int DEN_W   = 27;               // d * l, below 10 * clock / 11
  localparam int N_W     = CLK_W;            // clock - d * l
  localparam int C10_W   = CLK_W + 4;        // 10 * clock
  localparam int CHK_W   = DEN_W + 5;        // den * 19
  localparam int NM_W    = N_W + MUL_W;      // n * m
  localparam int ERR_W   = DEN_W + ADD_W;    // |n * m - a * den|
  localparam int EPROD_W = ERR_W + MUL_W;    // error scaled by a multiplier
  localparam int DVD_W   = 31;               // divider dividend and quotient
  localparam int DVS_W   = 34;               // divider divisor and remainder

  // Trial factors in tenths
  localparam logic [T_W-1:0] T_FIRST = 5'd15;
  localparam logic [T_W-1:0] T_LOW   = 5'd11;
  localparam logic [T_W-1:0] T_HIGH  = 5'd19;
  localparam logic [3:0]     T_SCALE = 4'd10;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_FRAC = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXACT,
    S_EXACT_W,
    S_TRY_MUL,
    S_TRY_DIV,
    S_TRY_W,
    S_TRY_DEN,
    S_TRY_CHK,
    S_FRAC_INIT,
    S_FRAC_DIV,
    S_FRAC_W,
    S_FRAC_ERR,
    S_FRAC_CMP,
    S_DONE
  } state_t;

endpackage

### design/ufbd_if.sv
// ----------------------------------------------------------------------------
// ufbd_if: valid/ready channels of the fractional baud divisor
// Request channel (clock, baud) and result channel (divisor, fraction, status).
// ----------------------------------------------------------------------------
interface ufbd_in_if import ufbd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CLK_W-1:0]  clock_hz;
  logic [BAUD_W-1:0] baud_rate;

  modport source (output valid, clock_hz, baud_rate, input ready);
  modport sink (input valid, clock_hz, baud_rate, output ready);
endinterface

interface ufbd_out_if import ufbd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIVL_W-1:0] divisor;
  logic [MUL_W-1:0]  mul_val;
  logic [ADD_W-1:0]  div_add_val;
  logic [STAT_W-1:0] status;

  modport source (output valid, divisor, mul_val, div_add_val, status, input ready);
  modport sink (input valid, divisor, mul_val, div_add_val, status, output ready);
endinterface

### design/uart_fractional_baud_divisor_top.sv
// A zero baud rate is answered without any division; the longest search runs all ten
//   trial factors and every multiplier.
// Concurrency: one transfer in flight; the next one is taken once the result is in
//   the output register. Each division runs in the shared radix-2 divider.
// Reset: synchronous, active low; clears the sequencer, divider control and out valid.
// ----------------------------------------------------------------------------
// uart_fractional_baud_divisor_top: UART fractional baud divisor calculator
// Finds the 16-bit divisor latch value and the (mul, divadd) fraction pair
// for a peripheral clock and baud rate with exact integer arithmetic.
// ----------------------------------------------------------------------------
module uart_fractional_baud_divisor_top import ufbd_pkg::*; #(
  parameter int MAX_MUL = 15
) (
  input  logic   clk,
  input  logic   rst_n,
  ufbd_in_if.sink    in_ch,
  ufbd_out_if.source out_ch
);

  // --------------------------------------------------------------------------
  // Sequencer and working registers
  // --------------------------------------------------------------------------
  state_t            state_r, state_nxt;

  logic [CLK_W-1:0]  clk_r, clk_nxt;        // peripheral clock
  logic [D_W-1:0]    d_r, d_nxt;            // 16 * baud
  logic [T_W-1:0]    t_r, t_nxt;            // trial factor in tenths
  logic              first_r, first_nxt;    // first trial (factor 1.5) pending
  logic [Q_W-1:0]    q_r, q_nxt;            // d * t
  logic [L_W-1:0]    l_r, l_nxt;            // trial divisor latch value
  logic [DEN_W-1:0]  den_r, den_nxt;        // d * l
  logic [N_W-1:0]    n_r, n_nxt;            // clock - d * l
  logic [MUL_W-1:0]  m_r, m_nxt;            // current multiplier
  logic [ADD_W-1:0]  a_r, a_nxt;            // rounded add value for m
  logic [MUL_W-1:0]  bm_r, bm_nxt;          // best multiplier so far
  logic [ADD_W-1:0]  ba_r, ba_nxt;          // best add value so far
  logic [ERR_W-1:0]  best_err_r, best_err_nxt;
  logic [ERR_W-1:0]  cur_err_r, cur_err_nxt;

  // Result held until the output register is free
  logic [DIVL_W-1:0] res_div_r, res_div_nxt;
  logic [MUL_W-1:0]  res_mul_r, res_mul_nxt;
  logic [ADD_W-1:0]  res_add_r, res_add_nxt;
  status_t           res_st_r, res_st_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [DIVL_W-1:0] out_div_r, out_div_nxt;
  logic [MUL_W-1:0]  out_mul_r, out_mul_nxt;
  logic [ADD_W-1:0]  out_add_r, out_add_nxt;
  status_t           out_st_r, out_st_nxt;

  // Handshakes and divider port
  logic              in_ready;
  logic              in_xfer;
  logic              out_load;
  logic              div_start;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic              div_done;
  logic [DVD_W-1:0]  div_quo;
  logic [DVS_W-1:0]  div_rem;

  // Decision terms
  logic              exact_hit;
  logic              exact_bad;
  logic              clk_lt_d;
  logic [C10_W-1:0]  clk10;
  logic [CHK_W-1:0]  den11;
  logic [CHK_W-1:0]  den19;
  logic              try_fail;
  logic              l_big;
  logic              trials_out;
  logic [D_W+L_W-1:0] den_full;
  logic [NM_W-1:0]   nm;
  logic [ERR_W-1:0]  aden;
  logic [EPROD_W-1:0] e_new;
  logic [EPROD_W-1:0] e_old;
  logic              take_new;
  logic              frac_last;

  // --------------------------------------------------------------------------
  // Shared divider: every quotient of the search goes through it
  // --------------------------------------------------------------------------
  ufbd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // --------------------------------------------------------------------------
  // Arithmetic around the divider
  // --------------------------------------------------------------------------
  always_comb begin
    exact_hit  = (div_rem == '0);
    // quotient zero (clock below 16 * baud) or too wide for the latch
    exact_bad  = (div_quo == '0) || (div_quo[DVD_W-1:DIVL_W] != '0);
    clk_lt_d   = ({2'b0, clk_r} < d_r);
    clk10      = C10_W'(clk_r) * C10_W'(T_SCALE);
    den11      = CHK_W'(den_r) * CHK_W'(T_LOW);
    den19      = CHK_W'(den_r) * CHK_W'(T_HIGH);
    // factor clock / den must lie within 1.1 .. 1.9
    try_fail   = (l_r == '0) || (CHK_W'(clk10) < den11) || (CHK_W'(clk10) > den19);
    l_big      = (l_r[L_W-1:DIVL_W] != '0);
    trials_out = !first_r && (t_r == T_HIGH);
    den_full   = d_r * l_r;
    nm         = NM_W'(n_r) * NM_W'(m_r);
    aden       = ERR_W'(a_r) * ERR_W'(den_r);
    e_new      = EPROD_W'(cur_err_r) * EPROD_W'(bm_r);
    e_old      = EPROD_W'(best_err_r) * EPROD_W'(m_r);
    take_new   = (e_new < e_old);
    frac_last  = (m_r == MUL_W'(MAX_MUL));
  end

  assign in_xfer  = in_ch.valid && in_ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = (in_ch.baud_rate == '0) ? S_DONE : S_EXACT;
        end
      end
      S_EXACT:     state_nxt = S_EXACT_W;
      S_EXACT_W: begin
        if (div_done) begin
          state_nxt = (exact_hit || clk_lt_d) ? S_DONE : S_TRY_MUL;
        end
      end
      S_TRY_MUL:   state_nxt = S_TRY_DIV;
      S_TRY_DIV:   state_nxt = S_TRY_W;
      S_TRY_W: begin
        if (div_done) begin
          state_nxt = S_TRY_DEN;
        end
      end
      S_TRY_DEN:   state_nxt = S_TRY_CHK;
      S_TRY_CHK: begin
        priority if (!try_fail) begin
          state_nxt = l_big ? S_DONE : S_FRAC_INIT;
        end else if (trials_out) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_TRY_MUL;
        end
      end
      S_FRAC_INIT: state_nxt = S_FRAC_DIV;
      S_FRAC_DIV:  state_nxt = S_FRAC_W;
      S_FRAC_W: begin
        if (div_done) begin
          state_nxt = S_FRAC_ERR;
        end
      end
      S_FRAC_ERR:  state_nxt = S_FRAC_CMP;
      S_FRAC_CMP:  state_nxt = frac_last ? S_DONE : S_FRAC_DIV;
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer outputs: handshake and divider operands
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    div_dvd   = DVD_W'(clk_r);
    div_dvs   = DVS_W'(d_r);
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_EXACT: begin
        // clock / (16 * baud): exact-multiple test
        div_start = 1'b1;
      end
      S_TRY_DIV: begin
        // 10 * clock / (16 * baud * t)
        div_start = 1'b1;
        div_dvd   = DVD_W'(clk10);
        div_dvs   = DVS_W'(q_r);
      end
      S_FRAC_DIV: begin
        // round half up: (2*n*m + den) / (2*den)
        div_start = 1'b1;
        div_dvd   = DVD_W'({nm, 1'b0}) + DVD_W'(den_r);
        div_dvs   = DVS_W'({den_r, 1'b0});
      end
      default: begin
        in_ready  = 1'b0;
        div_start = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath next values
  // --------------------------------------------------------------------------
  always_comb begin
    clk_nxt      = clk_r;
    d_nxt        = d_r;
    t_nxt        = t_r;
    first_nxt    = first_r;
    q_nxt        = q_r;
    l_nxt        = l_r;
    den_nxt      = den_r;
    n_nxt        = n_r;
    m_nxt        = m_r;
    a_nxt        = a_r;
    bm_nxt       = bm_r;
    ba_nxt       = ba_r;
    best_err_nxt = best_err_r;
    cur_err_nxt  = cur_err_r;
    res_div_nxt  = res_div_r;
    res_mul_nxt  = res_mul_r;
    res_add_nxt  = res_add_r;
    res_st_nxt   = res_st_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          clk_nxt     = in_ch.clock_hz;
          d_nxt       = {in_ch.baud_rate, 4'b0000};
          t_nxt       = T_FIRST;
          first_nxt   = 1'b1;
          // preset the error result; the success paths overwrite it
          res_div_nxt = '0;
          res_mul_nxt = MUL_W'(1);
          res_add_nxt = '0;
          res_st_nxt  = ST_RANGE;
        end
      end
      S_EXACT_W: begin
        if (div_done && exact_hit && !exact_bad) begin
          res_div_nxt = div_quo[DIVL_W-1:0];
          res_st_nxt  = ST_OK;
        end
      end
      S_TRY_MUL: q_nxt = Q_W'(d_r) * Q_W'(t_r);
      S_TRY_W: begin
        if (div_done) begin
          l_nxt = div_quo[L_W-1:0];
        end
      end
      S_TRY_DEN: den_nxt = den_full[DEN_W-1:0];
      S_TRY_CHK: begin
        priority if (!try_fail) begin
          n_nxt        = N_W'(DEN_W'(clk_r) - den_r);
          best_err_nxt = ERR_W'(N_W'(DEN_W'(clk_r) - den_r));
          bm_nxt       = MUL_W'(1);
          ba_nxt       = '0;
          m_nxt        = MUL_W'(1);
        end else if (trials_out) begin
          res_st_nxt = ST_NO_FRAC;
        end else if (first_r) begin
          // 1.5 missed: sweep from 1.1 upward
          first_nxt = 1'b0;
          t_nxt     = T_LOW;
        end else begin
          t_nxt = t_r + T_W'(1);
        end
      end
      S_FRAC_W: begin
        if (div_done) begin
          a_nxt = div_quo[ADD_W-1:0];
        end
      end
      S_FRAC_ERR: begin
        cur_err_nxt = (ERR_W'(nm) > aden) ? (ERR_W'(nm) - aden) : (aden - ERR_W'(nm));
      end
      S_FRAC_CMP: begin
        // compare |r - a/m| against the best by cross-multiplying the errors
        if (take_new) begin
          bm_nxt       = m_r;
          ba_nxt       = a_r;
          best_err_nxt = cur_err_r;
        end
        if (frac_last) begin
          res_div_nxt = l_r[DIVL_W-1:0];
          res_mul_nxt = take_new ? m_r : bm_r;
          res_add_nxt = take_new ? a_r : ba_r;
          res_st_nxt  = ST_OK;
        end else begin
          m_nxt = m_r + MUL_W'(1);
        end
      end
      default: begin
        clk_nxt = clk_r;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register: load from the held result, drop valid on transfer
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_div_nxt   = out_div_r;
    out_mul_nxt   = out_mul_r;
    out_add_nxt   = out_add_r;
    out_st_nxt    = out_st_r;
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
      out_div_nxt   = res_div_r;
      out_mul_nxt   = res_mul_r;
      out_add_nxt   = res_add_r;
      out_st_nxt    = res_st_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    clk_r      <= clk_nxt;
    d_r        <= d_nxt;
    t_r        <= t_nxt;
    first_r    <= first_nxt;
    q_r        <= q_nxt;
    l_r        <= l_nxt;
    den_r      <= den_nxt;
    n_r        <= n_nxt;
    m_r        <= m_nxt;
    a_r        <= a_nxt;
    bm_r       <= bm_nxt;
    ba_r       <= ba_nxt;
    best_err_r <= best_err_nxt;
    cur_err_r  <= cur_err_nxt;
    res_div_r  <= res_div_nxt;
    res_mul_r  <= res_mul_nxt;
    res_add_r  <= res_add_nxt;
    res_st_r   <= res_st_nxt;
    out_div_r  <= out_div_nxt;
    out_mul_r  <= out_mul_nxt;
    out_add_r  <= out_add_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.divisor     = out_div_r;
  assign out_ch.mul_val     = out_mul_r;
  assign out_ch.div_add_val = out_add_r;
  assign out_ch.status      = out_st_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_st_r == ST_OK)) |->
      (out_div_r != '0) && (out_mul_r != '0) && (out_add_r <= out_mul_r))
    else $error("ok result with an impossible divisor or fraction");

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_st_r != ST_OK)) |->
      (out_div_r == '0) && (out_mul_r == MUL_W'(1)) && (out_add_r == '0))
    else $error("error result without cleared fields");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |->
      ((state_r == S_EXACT_W) || (state_r == S_TRY_W) || (state_r == S_FRAC_W)))
    else $error("divider finished outside a wait state");

  a_trial_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TRY_MUL) |-> (t_r >= T_LOW) && (t_r <= T_HIGH))
    else $error("trial factor outside 1.1 .. 1.9");

  a_add_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FRAC_CMP) |-> (a_r <= m_r) && (m_r != '0))
    else $error("rounded add value exceeds its multiplier");

endmodule

### design/ufbd_div.sv
// ----------------------------------------------------------------------------
// ufbd_div: shared restoring divider
// One quotient bit per cycle; done pulses once quotient and remainder hold.
// ----------------------------------------------------------------------------
module ufbd_div import ufbd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;

  always_comb begin
    rem_sh   = {rem_r, quo_r[DVD_W-1]};
    rem_sub  = rem_sh - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    priority if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // restore when the trial subtraction borrows
      if (!rem_sub[DVS_W]) begin
        rem_nxt = rem_sub[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
